// ===== hdl/arbpm_pkg.sv =====
// Opcodes, register indexes and port widths shared by the audio ring buffer peak meter.
`default_nettype none
package arbpm_pkg;

  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [OP_W-1:0] OP_WRITE_BYTE   = 3'd0;
  localparam logic [OP_W-1:0] OP_COMMIT_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_COMMIT_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_PEAK    = 3'd4;
  localparam logic [OP_W-1:0] OP_DISCARD      = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_BYTE    = 3'd6;
  localparam logic [OP_W-1:0] OP_NOP          = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES  = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/audio_ring_buffer_peak_meter_unit.sv =====
// Audio byte ring buffer with per-channel peak meters, built around a byte RAM.
//
//   channel   handshake             payload
//   command   start / busy          opcode, address, write_data, position, channel
//   result    done (one cycle)      read_data, read_offset, available, peak, wake,
//                                   misaligned
//   config    cfg_write             cfg_index, cfg_data
//
// One command is worked at a time; busy stays high until its result is shown.
// Every remainder (ring trim, offsets modulo the ring, alignment to a frame) goes
// through one shared restoring divider. A commit write walks every sample that it
// wrote and reads each one a byte at a time, since the byte RAM has one port and
// returns one byte per cycle.
// Reset is synchronous; results are strobed for one cycle and cannot be stalled.
`default_nettype none
module audio_ring_buffer_peak_meter_unit #(
  parameter int MEM_BYTES    = 65536,
  parameter int MAX_CHANNELS = 8,
  parameter int WAKE_FRAMES  = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [arbpm_pkg::OP_W-1:0]       opcode,
  input  wire logic [15:0]                      address,
  input  wire logic [7:0]                       write_data,
  input  wire logic [16:0]                      position,
  input  wire logic [2:0]                       channel,
  output logic                                  done,
  output logic [7:0]                            read_data,
  output logic [15:0]                           read_offset,
  output logic [16:0]                           available,
  output logic [30:0]                           peak,
  output logic                                  wake,
  output logic                                  misaligned,
  input  wire logic                             cfg_write,
  input  wire logic [arbpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [arbpm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import arbpm_pkg::*;

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int RW   = (AW + 1 > 17) ? AW + 1 : 17;
  localparam int CW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WKW  = $clog2(WAKE_FRAMES + 1);
  localparam int FSW  = ((WKW > AW) ? WKW : AW) + 1;
  localparam int DW   = 33;

  typedef enum logic [3:0] {
    S_IDLE, S_RING, S_ADDR, S_MEMRD, S_NP, S_NPF, S_OLD, S_OLDF,
    S_WALK, S_WUPD, S_RO, S_DISC, S_PEAK
  } state_t;

  state_t state;

  logic [16:0]    cfg_ring;
  logic [3:0]     cfg_chans;
  logic           cfg_wide;

  logic [OP_W-1:0] op_code;
  logic [15:0]    op_addr;
  logic [7:0]     op_data;
  logic [16:0]    op_pos;
  logic [2:0]     op_chan;

  logic [AW-1:0]  wr_off;
  logic [AW-1:0]  rd_ptr;
  logic [31:0]    fill;
  logic [FSW-1:0] fsw;

  logic [RW-1:0]  ring;
  logic [RW-1:0]  np;
  logic [RW-1:0]  old;
  logic           mis;

  logic [DW-1:0]  div_num;
  logic [RW-1:0]  div_den;
  logic [RW-1:0]  div_rem;
  logic [5:0]     div_cnt;
  logic           div_done;
  logic [RW:0]    div_trial;
  logic [RW-1:0]  div_rem_next;

  logic [RW-1:0]  w_pos;
  logic [CW-1:0]  w_ch;
  logic [2:0]     w_byte;
  logic [RW-1:0]  frames;
  logic [31:0]    sample;

  logic [4:0]     ch_eff;
  logic [1:0]     sb_shift;
  logic [2:0]     sb_count;
  logic [RW-1:0]  frame;
  logic [RW-1:0]  ring_clamp;
  logic [RW-1:0]  ring_calc;
  logic           chan_ok;
  logic           walk_end;

  logic [7:0]     mem [MEM_BYTES];
  logic [AW-1:0]  mem_addr;
  logic           mem_we;
  logic [7:0]     mem_rdata;
  logic [AW-1:0]  walk_addr;

  logic [30:0]    pk_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] pk_valid;
  logic           pk_re;
  logic           pk_we;
  logic [CW-1:0]  pk_raddr;
  logic [CW-1:0]  pk_waddr;
  logic [30:0]    pk_wdata;
  logic [30:0]    pk_rdata;
  logic           pk_rd_valid;
  logic [30:0]    old_peak;

  logic [31:0]    neg32;
  logic [15:0]    s16;
  logic [30:0]    mag;

  logic [RW-1:0]  wr_bytes;
  logic [FSW-1:0] fsw_sum;
  logic [32:0]    query_sum;

  function automatic logic [RW-1:0] span(input logic [RW-1:0] dst,
                                         input logic [RW-1:0] src,
                                         input logic [RW-1:0] rng);
    logic [RW-1:0] res;
    if (dst >= src) res = dst - src;
    else res = dst + rng - src;
    return res;
  endfunction

  always_comb begin
    if (cfg_chans == 4'd0) ch_eff = 5'd1;
    else if (int'(cfg_chans) > MAX_CHANNELS) ch_eff = 5'(MAX_CHANNELS);
    else ch_eff = 5'(cfg_chans);
  end

  assign sb_shift   = cfg_wide ? 2'd2 : 2'd1;
  assign sb_count   = cfg_wide ? 3'd4 : 3'd2;
  assign frame      = RW'(ch_eff) << sb_shift;
  assign ring_clamp = (RW'(cfg_ring) > RW'(MEM_BYTES)) ? RW'(MEM_BYTES) : RW'(cfg_ring);
  assign chan_ok    = int'(op_chan) < MAX_CHANNELS;
  assign busy       = (state != S_IDLE);
  assign div_done   = (div_cnt == 6'd0);
  assign walk_end   = (w_byte == 3'd0) && (w_pos == np);

  always_comb begin
    ring_calc = ring_clamp - div_rem;
    if (ring_calc < frame) ring_calc = frame;
  end

  assign div_trial    = {div_rem, div_num[DW-1]};
  assign div_rem_next = (div_trial >= {1'b0, div_den}) ?
                        RW'(div_trial - {1'b0, div_den}) : RW'(div_trial);

  assign walk_addr = AW'(w_pos + (RW'(w_ch) << sb_shift) + RW'(w_byte));

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = walk_addr;
    if (state == S_ADDR) begin
      mem_addr = div_rem[AW-1:0];
      mem_we   = div_done && (op_code == OP_WRITE_BYTE);
    end
  end

  assign neg32 = 32'd0 - sample;
  assign s16   = sample[31:16];
  always_comb begin
    if (cfg_wide) begin
      if (!sample[31]) mag = sample[30:0];
      else if (neg32[31]) mag = 31'h7FFF_FFFF;
      else mag = neg32[30:0];
    end else begin
      if (s16[15]) mag = 31'(17'h10000 - {1'b0, s16});
      else mag = 31'(s16);
    end
  end

  assign old_peak = pk_rd_valid ? pk_rdata : 31'd0;

  always_comb begin
    pk_re    = 1'b0;
    pk_raddr = w_ch;
    pk_we    = 1'b0;
    pk_waddr = w_ch;
    pk_wdata = mag;
    if (state == S_IDLE) begin
      pk_raddr = CW'(channel);
      pk_re    = start && (opcode == OP_READ_PEAK);
    end
    if (state == S_WALK) pk_re = !walk_end && (w_byte == 3'd0);
    if (state == S_WUPD) pk_we = (mag > old_peak);
    if (state == S_PEAK) begin
      pk_we    = chan_ok;
      pk_waddr = CW'(op_chan);
      pk_wdata = 31'd0;
    end
  end

  assign wr_bytes  = span(np, old, ring);
  assign fsw_sum   = fsw + FSW'(frames);
  assign query_sum = {1'b0, fill} + 33'(div_rem);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= op_data;
    mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (pk_we) pk_mem[pk_waddr] <= pk_wdata;
    if (pk_re) pk_rdata <= pk_mem[pk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pk_valid    <= '0;
      pk_rd_valid <= 1'b0;
    end else begin
      if (pk_we) pk_valid[pk_waddr] <= 1'b1;
      if (pk_re) pk_rd_valid <= pk_valid[pk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      div_cnt   <= 6'd0;
      wr_off    <= '0;
      rd_ptr    <= '0;
      fill      <= 32'd0;
      fsw       <= '0;
      cfg_ring  <= 17'h10000;
      cfg_chans <= 4'd2;
      cfg_wide  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RING_SIZE:     cfg_ring  <= cfg_data[16:0];
          REG_CHANNEL_COUNT: cfg_chans <= cfg_data[3:0];
          REG_WIDE_SAMPLES:  cfg_wide  <= cfg_data[0];
          default: ;
        endcase
      end
      if (!div_done) begin
        div_rem <= div_rem_next;
        div_num <= div_num << 1;
        div_cnt <= div_cnt - 6'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_code     <= opcode;
            op_addr     <= address;
            op_data     <= write_data;
            op_pos      <= position;
            op_chan     <= channel;
            read_data   <= 8'd0;
            read_offset <= 16'd0;
            available   <= 17'd0;
            peak        <= 31'd0;
            wake        <= 1'b0;
            misaligned  <= 1'b0;
            mis         <= 1'b0;
            if (opcode == OP_READ_PEAK) begin
              state <= S_PEAK;
            end else if (opcode == OP_NOP) begin
              done <= 1'b1;
            end else begin
              div_num <= DW'(ring_clamp);
              div_den <= frame;
              div_rem <= '0;
              div_cnt <= 6'(DW);
              state   <= S_RING;
            end
          end
        end
        S_RING: begin
          if (div_done) begin
            ring    <= ring_calc;
            div_den <= ring_calc;
            div_rem <= '0;
            div_cnt <= 6'(DW);
            case (op_code) inside
              OP_WRITE_BYTE, OP_READ_BYTE: begin
                div_num <= DW'(op_addr);
                state   <= S_ADDR;
              end
              OP_COMMIT_WRITE, OP_COMMIT_READ: begin
                div_num <= DW'(op_pos);
                state   <= S_NP;
              end
              default: begin
                div_num <= DW'(rd_ptr);
                state   <= S_RO;
              end
            endcase
          end
        end
        S_ADDR: begin
          if (div_done) begin
            if (op_code == OP_READ_BYTE) begin
              state <= S_MEMRD;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_MEMRD: begin
          read_data <= mem_rdata;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_NP: begin
          if (div_done) begin
            np      <= div_rem;
            div_num <= DW'(div_rem);
            div_den <= frame;
            div_rem <= '0;
            div_cnt <= 6'(DW);
            state   <= S_NPF;
          end
        end
        S_NPF: begin
          if (div_done) begin
            np      <= np - div_rem;
            mis     <= (div_rem != '0);
            div_den <= ring;
            div_rem <= '0;
            div_cnt <= 6'(DW);
            if (op_code == OP_COMMIT_WRITE) begin
              div_num <= DW'(wr_off);
              state   <= S_OLD;
            end else begin
              div_num <= DW'(rd_ptr);
              state   <= S_RO;
            end
          end
        end
        S_OLD: begin
          if (div_done) begin
            old     <= div_rem;
            div_num <= DW'(div_rem);
            div_den <= frame;
            div_rem <= '0;
            div_cnt <= 6'(DW);
            state   <= S_OLDF;
          end
        end
        S_OLDF: begin
          if (div_done) begin
            old    <= old - div_rem;
            w_pos  <= old - div_rem;
            mis    <= mis || (div_rem != '0);
            w_ch   <= '0;
            w_byte <= 3'd0;
            frames <= '0;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_end) begin
            fill       <= fill + 32'(wr_bytes);
            wr_off     <= np[AW-1:0];
            misaligned <= mis;
            if (fsw_sum >= FSW'(WAKE_FRAMES)) begin
              wake <= 1'b1;
              fsw  <= '0;
            end else begin
              fsw <= fsw_sum;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (w_byte != 3'd0) sample <= {mem_rdata, sample[31:8]};
            if (w_byte == sb_count) begin
              w_byte <= 3'd0;
              state  <= S_WUPD;
            end else begin
              w_byte <= w_byte + 3'd1;
            end
          end
        end
        S_WUPD: begin
          if (w_ch == CW'(ch_eff - 5'd1)) begin
            w_ch   <= '0;
            frames <= frames + RW'(1);
            if (w_pos + frame >= ring) w_pos <= '0;
            else w_pos <= w_pos + frame;
          end else begin
            w_ch <= w_ch + CW'(1);
          end
          state <= S_WALK;
        end
        S_RO: begin
          if (div_done) begin
            case (op_code)
              OP_QUERY_READ: begin
                read_offset <= 16'(div_rem);
                if (query_sum > 33'(ring)) available <= 17'(ring - div_rem);
                else available <= fill[16:0];
                done  <= 1'b1;
                state <= S_IDLE;
              end
              OP_COMMIT_READ: begin
                fill       <= fill - 32'(span(np, div_rem, ring));
                rd_ptr     <= np[AW-1:0];
                misaligned <= mis;
                done       <= 1'b1;
                state      <= S_IDLE;
              end
              default: begin
                div_num <= query_sum;
                div_den <= ring;
                div_rem <= '0;
                div_cnt <= 6'(DW);
                state   <= S_DISC;
              end
            endcase
          end
        end
        S_DISC: begin
          if (div_done) begin
            rd_ptr <= div_rem[AW-1:0];
            fill   <= 32'd0;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_PEAK: begin
          peak  <= chan_ok ? old_peak : 31'd0;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("block not idle after reset");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> state == S_IDLE)
    else $error("result shown while a command is still in work");
  a_walk_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_WUPD) |-> (w_pos < ring && ring >= frame))
    else $error("peak walk left the ring");
  a_div_bound: assert property (@(posedge clk) disable iff (rst) div_cnt <= 6'(DW))
    else $error("divider step count out of range");
`endif

endmodule
`default_nettype wire
